### design/slhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slhp_pkg
// Shared types and constants for the sync-layer header parser.
// ----------------------------------------------------------------------------
package slhp_pkg;

  localparam int TIMESTAMP_WIDTH_DEF = 64;
  localparam int AU_LENGTH_WIDTH_DEF = 32;
  localparam int RATE_WIDTH_DEF      = 32;
  localparam int PAD_BITS            = 3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_AUS, PH_AUE, PH_OCRF, PH_IDLEF, PH_PADF, PH_PADB, PH_SEQ,
    PH_PRIF, PH_PRI, PH_OCR, PH_RAP, PH_AUSEQ, PH_DTSF, PH_CTSF, PH_RATEF,
    PH_DTS, PH_CTS, PH_AULEN, PH_RATE, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    F_AUS, F_AUE, F_OCR, F_IDLE, F_PAD, F_PRI, F_RAP, F_DTS, F_CTS, F_RATE
  } flag_idx_t;

  typedef enum logic [2:0] {
    CFG_USE_FLAGS, CFG_OCR_LEN, CFG_SEQ_LEN, CFG_PRI_LEN,
    CFG_AUSEQ_LEN, CFG_TS_LEN, CFG_AUL_LEN, CFG_RATE_LEN
  } cfg_idx_t;

  typedef struct packed {
    logic [5:0] use_flags;
    logic [6:0] ocr_len;
    logic [4:0] seq_len;
    logic [3:0] pri_len;
    logic [4:0] ausq_len;
    logic [6:0] ts_len;
    logic [5:0] aul_len;
    logic [5:0] rate_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       header_start;
  } item_t;

  typedef struct packed {
    logic [9:0]  flag_bits;
    logic [2:0]  padding_count;
    logic [15:0] packet_seq;
    logic [14:0] priority_value;
    logic [63:0] clock_ref;
    logic [15:0] au_seq;
    logic [63:0] decode_time;
    logic [63:0] compose_time;
    logic [31:0] au_size;
    logic [31:0] bit_rate;
    logic [5:0]  header_bytes;
  } result_t;

endpackage
`default_nettype wire

### design/slhp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slhp_in_if
// Header byte channel: valid/ready with one byte and its start mark.
// ----------------------------------------------------------------------------
interface slhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       header_start;

  modport source (output valid, output header_byte, output header_start, input ready);
  modport sink   (input valid, input header_byte, input header_start, output ready);
endinterface
`default_nettype wire

### design/slhp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slhp_out_if
// Parsed header channel: valid/ready with every header field.
// ----------------------------------------------------------------------------
interface slhp_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  flag_bits;
  logic [2:0]  padding_count;
  logic [15:0] packet_seq;
  logic [14:0] priority_value;
  logic [63:0] clock_ref;
  logic [15:0] au_seq;
  logic [63:0] decode_time;
  logic [63:0] compose_time;
  logic [31:0] au_size;
  logic [31:0] bit_rate;
  logic [5:0]  header_bytes;

  modport source (output valid, output flag_bits, output padding_count, output packet_seq,
                  output priority_value, output clock_ref, output au_seq,
                  output decode_time, output compose_time, output au_size,
                  output bit_rate, output header_bytes, input ready);
  modport sink   (input valid, input flag_bits, input padding_count, input packet_seq,
                  input priority_value, input clock_ref, input au_seq,
                  input decode_time, input compose_time, input au_size,
                  input bit_rate, input header_bytes, output ready);
endinterface
`default_nettype wire

### design/slhp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slhp_front
// Input side: accepts header words into a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module slhp_front
  import slhp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### design/slhp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slhp_back
// Parser: shifts header bits into fields and finds the next present field.
// ----------------------------------------------------------------------------
module slhp_back
  import slhp_pkg::*;
#(
  parameter int TIMESTAMP_WIDTH = TIMESTAMP_WIDTH_DEF,
  parameter int AU_LENGTH_WIDTH = AU_LENGTH_WIDTH_DEF,
  parameter int RATE_WIDTH      = RATE_WIDTH_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire item_t pop_item,
  output logic       emit_valid,
  input  wire logic  emit_ready,
  output result_t    emit_data
);

  phase_t      phase_r, phase_nxt;
  phase_t      seek_from_r, seek_from_nxt;
  logic        seek_r, seek_nxt;
  logic        start_r, start_nxt;
  logic [6:0]  left_r, left_nxt;
  logic [3:0]  avail_r, avail_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic [9:0]  flags_r, flags_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [14:0] pri_r, pri_nxt;
  logic [63:0] ocr_r, ocr_nxt;
  logic [15:0] ausq_r, ausq_nxt;
  logic [63:0] dts_r, dts_nxt;
  logic [63:0] cts_r, cts_nxt;
  logic [31:0] aul_r, aul_nxt;
  logic [31:0] rate_r, rate_nxt;

  logic [6:0]  seq_sat, ocr_sat, ausq_sat, ts_sat, aul_sat, rate_sat;
  logic        body, au;
  logic [6:0]  lens [32];
  phase_t      found;
  logic [3:0]  take;
  logic [63:0] acc_sh;
  logic        pop;

  // Saturate configured widths to each field's maximum.
  always_comb begin
    seq_sat  = (cfg.seq_len > 5'd16) ? 7'd16 : 7'(cfg.seq_len);
    ocr_sat  = (cfg.ocr_len > 7'd64) ? 7'd64 : cfg.ocr_len;
    ausq_sat = (cfg.ausq_len > 5'd16) ? 7'd16 : 7'(cfg.ausq_len);
    ts_sat   = (cfg.ts_len > 7'(TIMESTAMP_WIDTH)) ? 7'(TIMESTAMP_WIDTH) : cfg.ts_len;
    aul_sat  = (7'(cfg.aul_len) > 7'(AU_LENGTH_WIDTH)) ? 7'(AU_LENGTH_WIDTH)
                                                      : 7'(cfg.aul_len);
    rate_sat = (7'(cfg.rate_len) > 7'(RATE_WIDTH)) ? 7'(RATE_WIDTH) : 7'(cfg.rate_len);
  end

  // Per-phase length and first present phase at or after seek_from_r.
  always_comb begin
    body = !flags_r[F_IDLE] && (!flags_r[F_PAD] || pad_r != 3'd0);
    au   = body && flags_r[F_AUS];
    for (int i = 0; i < 32; i++) begin
      case (phase_t'(5'(i)))
        PH_AUS:   lens[i] = cfg.use_flags[0] ? 7'd1 : 7'd0;
        PH_AUE:   lens[i] = cfg.use_flags[1] ? 7'd1 : 7'd0;
        PH_OCRF:  lens[i] = (cfg.ocr_len != 7'd0) ? 7'd1 : 7'd0;
        PH_IDLEF: lens[i] = cfg.use_flags[2] ? 7'd1 : 7'd0;
        PH_PADF:  lens[i] = cfg.use_flags[3] ? 7'd1 : 7'd0;
        PH_PADB:  lens[i] = flags_r[F_PAD] ? 7'(PAD_BITS) : 7'd0;
        PH_SEQ:   lens[i] = body ? seq_sat : 7'd0;
        PH_PRIF:  lens[i] = (body && cfg.pri_len != 4'd0) ? 7'd1 : 7'd0;
        PH_PRI:   lens[i] = (body && flags_r[F_PRI]) ? 7'(cfg.pri_len) : 7'd0;
        PH_OCR:   lens[i] = (body && flags_r[F_OCR]) ? ocr_sat : 7'd0;
        PH_RAP:   lens[i] = (au && cfg.use_flags[4]) ? 7'd1 : 7'd0;
        PH_AUSEQ: lens[i] = au ? ausq_sat : 7'd0;
        PH_DTSF:  lens[i] = (au && cfg.use_flags[5]) ? 7'd1 : 7'd0;
        PH_CTSF:  lens[i] = (au && cfg.use_flags[5]) ? 7'd1 : 7'd0;
        PH_RATEF: lens[i] = (au && cfg.rate_len != 6'd0) ? 7'd1 : 7'd0;
        PH_DTS:   lens[i] = (au && flags_r[F_DTS]) ? ts_sat : 7'd0;
        PH_CTS:   lens[i] = (au && flags_r[F_CTS]) ? ts_sat : 7'd0;
        PH_AULEN: lens[i] = au ? aul_sat : 7'd0;
        PH_RATE:  lens[i] = (au && flags_r[F_RATE]) ? rate_sat : 7'd0;
        default:  lens[i] = 7'd0;
      endcase
    end
    found = PH_DONE;
    for (int i = PH_RATE; i >= PH_AUS; i--) begin
      if (5'(i) >= seek_from_r && lens[i] != 7'd0) begin
        found = phase_t'(5'(i));
      end
    end
  end

  // Bits taken from the current byte this cycle and the shifted field value.
  always_comb begin
    take   = (7'(avail_r) < left_r) ? avail_r : left_r[3:0];
    acc_sh = (accum_r << take) | 64'(byte_r >> (4'd8 - take));
  end

  assign pop_ready  = !seek_r && avail_r == 4'd0;
  assign pop        = pop_valid && pop_ready;
  assign emit_valid = seek_r && found == PH_DONE;

  always_comb begin
    emit_data.flag_bits      = flags_r;
    emit_data.padding_count  = pad_r;
    emit_data.packet_seq     = seq_r;
    emit_data.priority_value = pri_r;
    emit_data.clock_ref      = ocr_r;
    emit_data.au_seq         = ausq_r;
    emit_data.decode_time    = dts_r;
    emit_data.compose_time   = cts_r;
    emit_data.au_size        = aul_r;
    emit_data.bit_rate       = rate_r;
    emit_data.header_bytes   = cnt_r;
  end

  always_comb begin
    phase_nxt     = phase_r;
    seek_from_nxt = seek_from_r;
    seek_nxt      = seek_r;
    start_nxt     = start_r;
    left_nxt      = left_r;
    avail_nxt     = avail_r;
    byte_nxt      = byte_r;
    accum_nxt     = accum_r;
    cnt_nxt       = cnt_r;
    flags_nxt     = flags_r;
    pad_nxt       = pad_r;
    seq_nxt       = seq_r;
    pri_nxt       = pri_r;
    ocr_nxt       = ocr_r;
    ausq_nxt      = ausq_r;
    dts_nxt       = dts_r;
    cts_nxt       = cts_r;
    aul_nxt       = aul_r;
    rate_nxt      = rate_r;
    if (seek_r) begin
      if (found == PH_DONE) begin
        // Header finished: drop the rest of the byte once the result is taken.
        if (emit_ready) begin
          phase_nxt = PH_DONE;
          seek_nxt  = 1'b0;
          start_nxt = 1'b0;
          avail_nxt = 4'd0;
          left_nxt  = 7'd0;
        end
      end else begin
        phase_nxt = found;
        left_nxt  = lens[found];
        accum_nxt = 64'd0;
        seek_nxt  = 1'b0;
        if (start_r) begin
          cnt_nxt   = cnt_r + 6'd1;
          start_nxt = 1'b0;
        end
      end
    end else if (avail_r != 4'd0) begin
      accum_nxt = acc_sh;
      left_nxt  = left_r - 7'(take);
      avail_nxt = avail_r - take;
      byte_nxt  = byte_r << take;
      if (left_r == 7'(take)) begin
        seek_nxt      = 1'b1;
        seek_from_nxt = phase_t'(phase_r + 5'd1);
        case (phase_r)
          PH_AUS:   flags_nxt[F_AUS]  = acc_sh[0];
          PH_AUE:   flags_nxt[F_AUE]  = acc_sh[0];
          PH_OCRF:  flags_nxt[F_OCR]  = acc_sh[0];
          PH_IDLEF: flags_nxt[F_IDLE] = acc_sh[0];
          PH_PADF:  flags_nxt[F_PAD]  = acc_sh[0];
          PH_PADB:  pad_nxt  = acc_sh[2:0];
          PH_SEQ:   seq_nxt  = acc_sh[15:0];
          PH_PRIF:  flags_nxt[F_PRI]  = acc_sh[0];
          PH_PRI:   pri_nxt  = acc_sh[14:0];
          PH_OCR:   ocr_nxt  = acc_sh;
          PH_RAP:   flags_nxt[F_RAP]  = acc_sh[0];
          PH_AUSEQ: ausq_nxt = acc_sh[15:0];
          PH_DTSF:  flags_nxt[F_DTS]  = acc_sh[0];
          PH_CTSF:  flags_nxt[F_CTS]  = acc_sh[0];
          PH_RATEF: flags_nxt[F_RATE] = acc_sh[0];
          PH_DTS:   dts_nxt  = acc_sh;
          PH_CTS:   cts_nxt  = acc_sh;
          PH_AULEN: aul_nxt  = acc_sh[31:0];
          PH_RATE:  rate_nxt = acc_sh[31:0];
          default:  ;
        endcase
      end
    end else if (pop) begin
      if (pop_item.header_start) begin
        // New header: clear captures and look for its first field.
        flags_nxt     = 10'b0;
        flags_nxt[F_AUS] = 1'b1;
        flags_nxt[F_AUE] = 1'b1;
        pad_nxt       = 3'd0;
        seq_nxt       = 16'd0;
        pri_nxt       = 15'd0;
        ocr_nxt       = 64'd0;
        ausq_nxt      = 16'd0;
        dts_nxt       = 64'd0;
        cts_nxt       = 64'd0;
        aul_nxt       = 32'd0;
        rate_nxt      = 32'd0;
        cnt_nxt       = 6'd0;
        seek_nxt      = 1'b1;
        seek_from_nxt = PH_AUS;
        start_nxt     = 1'b1;
        byte_nxt      = pop_item.header_byte;
        avail_nxt     = 4'd8;
      end else if (phase_r != PH_IDLE && phase_r != PH_DONE) begin
        cnt_nxt   = cnt_r + 6'd1;
        byte_nxt  = pop_item.header_byte;
        avail_nxt = 4'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seek_from_r <= PH_AUS;
      seek_r      <= 1'b0;
      start_r     <= 1'b0;
      left_r      <= 7'd0;
      avail_r     <= 4'd0;
      cnt_r       <= 6'd0;
      flags_r     <= 10'b11;
      pad_r       <= 3'd0;
    end else begin
      phase_r     <= phase_nxt;
      seek_from_r <= seek_from_nxt;
      seek_r      <= seek_nxt;
      start_r     <= start_nxt;
      left_r      <= left_nxt;
      avail_r     <= avail_nxt;
      cnt_r       <= cnt_nxt;
      flags_r     <= flags_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    accum_r <= accum_nxt;
    seq_r   <= seq_nxt;
    pri_r   <= pri_nxt;
    ocr_r   <= ocr_nxt;
    ausq_r  <= ausq_nxt;
    dts_r   <= dts_nxt;
    cts_r   <= cts_nxt;
    aul_r   <= aul_nxt;
    rate_r  <= rate_nxt;
  end

`ifndef ASSERT_OFF
  a_emit_from_seek: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid |-> seek_r) else $error("result raised outside a field search");

  a_shift_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (!seek_r && avail_r != 4'd0) |-> (phase_r != PH_IDLE && phase_r != PH_DONE
                                      && left_r != 7'd0))
    else $error("bits shifted with no open field");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && !emit_ready) |=> (seek_r && $stable(cnt_r)))
    else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

### design/sync_layer_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_layer_header_parser
// Reads sync-layer packet header fields from a byte stream, one result per
// completed header, using widths and presence from the configuration registers.
// ----------------------------------------------------------------------------
// Flow: each byte is loaded, then shifted into each field it ends or carries
//   on, with a next-field search after each field it ends; the final search
//   offers the result, which the output register takes when empty or drained.
// Throughput: one word per cycle into a two-entry queue while it has room;
//   the parser takes a new byte only once the last is shifted out and searched.
// Reset: synchronous active-low rst_n clears queue, parser and registers;
//   timestamp_length resets to 32, all other registers to 0.
module sync_layer_header_parser
  import slhp_pkg::*;
#(
  parameter int TIMESTAMP_WIDTH = TIMESTAMP_WIDTH_DEF,
  parameter int AU_LENGTH_WIDTH = AU_LENGTH_WIDTH_DEF,
  parameter int RATE_WIDTH      = RATE_WIDTH_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  slhp_in_if.sink         in_ch,
  slhp_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  item_t   push_item, pop_item;
  logic    pop_valid, pop_ready;
  logic    emit_valid, emit_ready;
  result_t emit_data;
  result_t out_r;
  logic    out_valid_r, out_valid_nxt;

  // Configuration writes: take the low bits of the word for each register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_USE_FLAGS: cfg_nxt.use_flags = cfg_wdata[5:0];
        CFG_OCR_LEN:   cfg_nxt.ocr_len   = cfg_wdata;
        CFG_SEQ_LEN:   cfg_nxt.seq_len   = cfg_wdata[4:0];
        CFG_PRI_LEN:   cfg_nxt.pri_len   = cfg_wdata[3:0];
        CFG_AUSEQ_LEN: cfg_nxt.ausq_len  = cfg_wdata[4:0];
        CFG_TS_LEN:    cfg_nxt.ts_len    = cfg_wdata;
        CFG_AUL_LEN:   cfg_nxt.aul_len   = cfg_wdata[5:0];
        CFG_RATE_LEN:  cfg_nxt.rate_len  = cfg_wdata[5:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{use_flags: 6'd0, ocr_len: 7'd0, seq_len: 5'd0, pri_len: 4'd0,
                 ausq_len: 5'd0, ts_len: 7'd32, aul_len: 6'd0, rate_len: 6'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: queue the incoming words.
  assign push_item.header_byte  = in_ch.header_byte;
  assign push_item.header_start = in_ch.header_start;

  slhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: parse bits into fields.
  slhp_back #(
    .TIMESTAMP_WIDTH (TIMESTAMP_WIDTH),
    .AU_LENGTH_WIDTH (AU_LENGTH_WIDTH),
    .RATE_WIDTH      (RATE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  // Output register: load when empty or being drained, hold otherwise.
  assign emit_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_valid && emit_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_r <= emit_data;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.flag_bits      = out_r.flag_bits;
  assign out_ch.padding_count  = out_r.padding_count;
  assign out_ch.packet_seq     = out_r.packet_seq;
  assign out_ch.priority_value = out_r.priority_value;
  assign out_ch.clock_ref      = out_r.clock_ref;
  assign out_ch.au_seq         = out_r.au_seq;
  assign out_ch.decode_time    = out_r.decode_time;
  assign out_ch.compose_time   = out_r.compose_time;
  assign out_ch.au_size        = out_r.au_size;
  assign out_ch.bit_rate       = out_r.bit_rate;
  assign out_ch.header_bytes   = out_r.header_bytes;

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sync_layer_header_parser. It sends header bytes
// through a valid/ready channel in random bursts. A bit-serial header model
// inside the bench predicts each parsed header. Results are compared field by
// field as they leave the block under a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb;
  import slhp_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 300;   // worst-case byte plus the two queued behind it
  localparam int NUM_WORDS   = 1800;

  // slots of the captured header fields
  localparam int S_FLAGS = 0, S_PAD = 1, S_SEQ = 2, S_PRI = 3, S_OCR = 4;
  localparam int S_AUSEQ = 5, S_DTS = 6, S_CTS = 7, S_AULEN = 8, S_RATE = 9;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  slhp_in_if  in_ch ();
  slhp_out_if out_ch ();

  sync_layer_header_parser dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Header model: registers, captured fields and parse position.
  // --------------------------------------------------------------------------
  logic [5:0]  hm_use;
  logic [6:0]  hm_ocr_len, hm_ts_len;
  logic [4:0]  hm_seq_len, hm_ausq_len;
  logic [3:0]  hm_pri_len;
  logic [5:0]  hm_aul_len, hm_rate_len;
  logic [63:0] hm_cap [10];
  int          hm_phase;
  int          hm_left;
  logic [63:0] hm_accum;
  logic [5:0]  hm_nbytes;

  result_t pending_headers [$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      hold_req = 1'b0;

  function automatic int sat(int v, int mx);
    return (v > mx) ? mx : v;
  endfunction

  function automatic void clear_fields();
    for (int i = 0; i < 10; i++) hm_cap[i] = '0;
    hm_cap[S_FLAGS][F_AUS] = 1'b1;
    hm_cap[S_FLAGS][F_AUE] = 1'b1;
  endfunction

  // Bits the phase reads with the registers and flags as they stand now.
  function automatic int field_len(int p);
    bit body;
    bit au;
    logic [63:0] f;
    f = hm_cap[S_FLAGS];
    body = !f[F_IDLE] && (!f[F_PAD] || hm_cap[S_PAD] != 0);
    au = body && f[F_AUS];
    case (p)
      PH_AUS:   return hm_use[0];
      PH_AUE:   return hm_use[1];
      PH_OCRF:  return hm_ocr_len != 0;
      PH_IDLEF: return hm_use[2];
      PH_PADF:  return hm_use[3];
      PH_PADB:  return f[F_PAD] ? PAD_BITS : 0;
      PH_SEQ:   return body ? sat(hm_seq_len, 16) : 0;
      PH_PRIF:  return body && hm_pri_len != 0;
      PH_PRI:   return (body && f[F_PRI]) ? sat(hm_pri_len, 15) : 0;
      PH_OCR:   return (body && f[F_OCR]) ? sat(hm_ocr_len, 64) : 0;
      PH_RAP:   return au && hm_use[4];
      PH_AUSEQ: return au ? sat(hm_ausq_len, 16) : 0;
      PH_DTSF, PH_CTSF: return au && hm_use[5];
      PH_RATEF: return au && hm_rate_len != 0;
      PH_DTS:   return (au && f[F_DTS]) ? sat(hm_ts_len, TIMESTAMP_WIDTH_DEF) : 0;
      PH_CTS:   return (au && f[F_CTS]) ? sat(hm_ts_len, TIMESTAMP_WIDTH_DEF) : 0;
      PH_AULEN: return au ? sat(hm_aul_len, AU_LENGTH_WIDTH_DEF) : 0;
      PH_RATE:  return (au && f[F_RATE]) ? sat(hm_rate_len, RATE_WIDTH_DEF) : 0;
      default:  return 0;
    endcase
  endfunction

  // Skip ahead to the first phase that reads anything.
  function automatic void seek_field(int p);
    int n;
    while (p < PH_DONE) begin
      n = field_len(p);
      if (n != 0) begin
        hm_phase = p;
        hm_left = n;
        hm_accum = '0;
        return;
      end
      p++;
    end
    hm_phase = PH_DONE;
    hm_left = 0;
  endfunction

  function automatic void store_field(int p, logic [63:0] v);
    case (p)
      PH_AUS:   hm_cap[S_FLAGS][F_AUS]  = v[0];
      PH_AUE:   hm_cap[S_FLAGS][F_AUE]  = v[0];
      PH_OCRF:  hm_cap[S_FLAGS][F_OCR]  = v[0];
      PH_IDLEF: hm_cap[S_FLAGS][F_IDLE] = v[0];
      PH_PADF:  hm_cap[S_FLAGS][F_PAD]  = v[0];
      PH_PADB:  hm_cap[S_PAD] = v;
      PH_SEQ:   hm_cap[S_SEQ] = v;
      PH_PRIF:  hm_cap[S_FLAGS][F_PRI]  = v[0];
      PH_PRI:   hm_cap[S_PRI] = v;
      PH_OCR:   hm_cap[S_OCR] = v;
      PH_RAP:   hm_cap[S_FLAGS][F_RAP]  = v[0];
      PH_AUSEQ: hm_cap[S_AUSEQ] = v;
      PH_DTSF:  hm_cap[S_FLAGS][F_DTS]  = v[0];
      PH_CTSF:  hm_cap[S_FLAGS][F_CTS]  = v[0];
      PH_RATEF: hm_cap[S_FLAGS][F_RATE] = v[0];
      PH_DTS:   hm_cap[S_DTS] = v;
      PH_CTS:   hm_cap[S_CTS] = v;
      PH_AULEN: hm_cap[S_AULEN] = v;
      PH_RATE:  hm_cap[S_RATE] = v;
      default: ;
    endcase
  endfunction

  function automatic result_t header_record();
    result_t r;
    r.flag_bits      = hm_cap[S_FLAGS][9:0];
    r.padding_count  = hm_cap[S_PAD][2:0];
    r.packet_seq     = hm_cap[S_SEQ][15:0];
    r.priority_value = hm_cap[S_PRI][14:0];
    r.clock_ref      = hm_cap[S_OCR];
    r.au_seq         = hm_cap[S_AUSEQ][15:0];
    r.decode_time    = hm_cap[S_DTS];
    r.compose_time   = hm_cap[S_CTS];
    r.au_size        = hm_cap[S_AULEN][31:0];
    r.bit_rate       = hm_cap[S_RATE][31:0];
    r.header_bytes   = hm_nbytes;
    return r;
  endfunction

  // Feed one accepted word to the model; return 1 when it completes a header.
  function automatic bit parse_word(input logic [7:0] b, input bit st,
                                    output result_t r);
    int p;
    if (st) begin
      clear_fields();
      hm_nbytes = '0;
      seek_field(PH_AUS);
      if (hm_phase == PH_DONE) begin
        r = header_record();
        return 1'b1;
      end
    end
    if (hm_phase == PH_IDLE || hm_phase == PH_DONE) return 1'b0;
    hm_nbytes++;
    for (int i = 7; i >= 0 && hm_phase != PH_DONE; i--) begin
      hm_accum = {hm_accum[62:0], b[i]};
      hm_left--;
      if (hm_left == 0) begin
        p = hm_phase;
        store_field(p, hm_accum);
        seek_field(p + 1);
      end
    end
    if (hm_phase == PH_DONE) begin
      r = header_record();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.header_byte = '0;
    in_ch.header_start = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic write_reg(cfg_idx_t idx, int v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_USE_FLAGS: hm_use      = v[5:0];
      CFG_OCR_LEN:   hm_ocr_len  = v[6:0];
      CFG_SEQ_LEN:   hm_seq_len  = v[4:0];
      CFG_PRI_LEN:   hm_pri_len  = v[3:0];
      CFG_AUSEQ_LEN: hm_ausq_len = v[4:0];
      CFG_TS_LEN:    hm_ts_len   = v[6:0];
      CFG_AUL_LEN:   hm_aul_len  = v[5:0];
      CFG_RATE_LEN:  hm_rate_len = v[5:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int u, int o, int s, int p, int a, int t, int l, int r);
    write_reg(CFG_USE_FLAGS, u); write_reg(CFG_OCR_LEN, o);
    write_reg(CFG_SEQ_LEN, s);   write_reg(CFG_PRI_LEN, p);
    write_reg(CFG_AUSEQ_LEN, a); write_reg(CFG_TS_LEN, t);
    write_reg(CFG_AUL_LEN, l);   write_reg(CFG_RATE_LEN, r);
  endtask

  // Hold the sender until every header is out, then let ignored words settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  int burst_left = 0;

  // Offer one word, wait for the handshake, then predict. Valid stays high
  // into the next word unless a gap is due.
  task automatic send_word(logic [7:0] b, bit st, output bit done, output result_t r);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.header_byte = b;
    in_ch.header_start = st;
    do @(posedge clk); while (!in_ch.ready);
    done = parse_word(b, st, r);
    if (done) pending_headers.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic note_mismatch(string name, logic [63:0] e, logic [63:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", name, e, a);
  endtask

  // Check each header leaving the block against the oldest prediction.
  always @(posedge clk) begin
    result_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.flag_bits, out_ch.padding_count, out_ch.packet_seq,
             out_ch.priority_value, out_ch.clock_ref, out_ch.au_seq,
             out_ch.decode_time, out_ch.compose_time, out_ch.au_size,
             out_ch.bit_rate, out_ch.header_bytes};
      if (pending_headers.size() == 0) begin
        note_mismatch("unexpected header", '0, got.flag_bits);
      end else begin
        want = pending_headers.pop_front();
        if (got.flag_bits != want.flag_bits)
          note_mismatch("flag_bits", want.flag_bits, got.flag_bits);
        if (got.padding_count != want.padding_count)
          note_mismatch("padding_count", want.padding_count, got.padding_count);
        if (got.packet_seq != want.packet_seq)
          note_mismatch("packet_seq", want.packet_seq, got.packet_seq);
        if (got.priority_value != want.priority_value)
          note_mismatch("priority_value", want.priority_value, got.priority_value);
        if (got.clock_ref != want.clock_ref)
          note_mismatch("clock_ref", want.clock_ref, got.clock_ref);
        if (got.au_seq != want.au_seq)
          note_mismatch("au_seq", want.au_seq, got.au_seq);
        if (got.decode_time != want.decode_time)
          note_mismatch("decode_time", want.decode_time, got.decode_time);
        if (got.compose_time != want.compose_time)
          note_mismatch("compose_time", want.compose_time, got.compose_time);
        if (got.au_size != want.au_size)
          note_mismatch("au_size", want.au_size, got.au_size);
        if (got.bit_rate != want.bit_rate)
          note_mismatch("bit_rate", want.bit_rate, got.bit_rate);
        if (got.header_bytes != want.header_bytes)
          note_mismatch("header_bytes", want.header_bytes, got.header_bytes);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  typedef struct {
    bit         max_cfg;   // write the oversized config before this word
    bit         st;
    logic [7:0] b;
    bit         known;     // flags and length typed in below
    logic [9:0] flags;
    logic [5:0] nbytes;
  } word_row_t;

  // Reset config selects no bits: start word alone gives an empty header.
  // Oversized config: 0xFF sets idle, so only flags and padding are read.
  // All-zero header under oversized config: 5 flags, 16 seq, 1 pri flag.
  word_row_t dir_rows [] = '{
    '{0, 1, 8'hA5, 1, 10'h003, 6'd0},
    '{0, 0, 8'h5A, 0, '0, '0},       // outside a header: drop
    '{0, 1, 8'h00, 1, 10'h003, 6'd0},
    '{1, 1, 8'hFF, 1, 10'h01F, 6'd1},
    '{0, 0, 8'h00, 0, '0, '0},       // after a completed header: drop
    '{0, 1, 8'h00, 0, '0, '0},
    '{0, 0, 8'h00, 0, '0, '0},
    '{0, 0, 8'h00, 1, 10'h000, 6'd3},
    '{0, 1, 8'hE0, 0, '0, '0},       // abandoned by the next start
    '{0, 0, 8'hFF, 0, '0, '0},
    '{0, 1, 8'hC8, 0, '0, '0},       // padding set with zero padding bits
    '{0, 0, 8'h00, 0, '0, '0},
    '{0, 1, 8'h88, 0, '0, '0},       // padding set, zero padding bits again: body skipped
    '{0, 0, 8'hFF, 0, '0, '0},
    '{0, 0, 8'hFF, 0, '0, '0},
    '{0, 0, 8'h7F, 0, '0, '0},
    '{0, 0, 8'h80, 0, '0, '0},
    '{0, 0, 8'h01, 0, '0, '0}
  };

  function automatic int rand_len(int hi, int over);
    case ($urandom_range(0, 9))
      0: return over;
      1: return hi;
      2: return 0;
      default: return $urandom_range(0, (hi < 10) ? hi : 10);
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    bit      done;
    result_t r;
    int      words;
    int      nb;
    int      phase_no;
    bit      active;

    hm_use = '0; hm_ocr_len = '0; hm_seq_len = '0; hm_pri_len = '0;
    hm_ausq_len = '0; hm_ts_len = 7'd32; hm_aul_len = '0; hm_rate_len = '0;
    hm_phase = PH_IDLE; hm_left = 0; hm_accum = '0; hm_nbytes = '0;
    clear_fields();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed walk
    foreach (dir_rows[i]) begin
      if (dir_rows[i].max_cfg) begin
        drain();
        write_all(63, 127, 31, 15, 31, 127, 63, 63);
      end
      send_word(dir_rows[i].b, dir_rows[i].st, done, r);
      if (dir_rows[i].known &&
          (!done || r.flag_bits != dir_rows[i].flags ||
           r.header_bytes != dir_rows[i].nbytes))
        note_mismatch("directed row", {dir_rows[i].flags, dir_rows[i].nbytes},
                      {r.flag_bits, r.header_bytes});
    end

    // random phases: a fresh config each, then well-formed headers with noise
    words = 0;
    phase_no = 0;
    while (words < NUM_WORDS) begin
      drain();
      case (phase_no)
        0: write_all(63, 127, 31, 15, 31, 127, 63, 63);
        1: write_all(0, 0, 0, 0, 0, 0, 0, 0);
        2: write_all(63, 64, 16, 15, 16, 64, 32, 32);
        3: write_all(63, 1, 1, 1, 1, 1, 1, 1);
        default:
          write_all($urandom_range(0, 63), rand_len(64, 127), rand_len(16, 31),
                    rand_len(15, 15), rand_len(16, 31), rand_len(64, 127),
                    rand_len(32, 63), rand_len(32, 63));
      endcase
      if (phase_no == 3) hold_req = 1'b1;   // fill the block while results stall
      repeat (60) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise: a bare word, dropped unless a header is open
            active = (hm_phase != PH_IDLE && hm_phase != PH_DONE);
            send_word(rand_byte(), 1'b0, done, r);
            if (active) words++;
          end
          1: begin
            // short header: a start and at most three more words, cut off by the next start if still open
            send_word(rand_byte(), 1'b1, done, r);
            words++;
            nb = $urandom_range(0, 3);
            for (int k = 0; k < nb && hm_phase != PH_DONE; k++) begin
              send_word(rand_byte(), 1'b0, done, r);
              words++;
            end
          end
          default: begin
            send_word(rand_byte(), 1'b1, done, r);
            words++;
            while (!done) begin
              send_word(rand_byte(), 1'b0, done, r);
              words++;
            end
          end
        endcase
      end
      phase_no++;
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/slhp_pkg.sv
design/slhp_in_if.sv
design/slhp_out_if.sv
design/slhp_front.sv
design/slhp_back.sv
design/sync_layer_header_parser.sv
bench/tb.sv
